>>> rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Each macro samples on the rising clock edge and is disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMAVG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("imavg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IMAVG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("imavg assertion failed");

`endif

>>> rtl/imavg_pkg.sv
`timescale 1ns / 1ps

package imavg_pkg;

  // Widths of the sample, the window register and the average.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WIN_CFG_W  = 7;
  localparam int unsigned AVG_W      = 16;

  // Window length after reset and the default depth of the sample ring.
  localparam int unsigned DEF_WINDOW = 16;
  localparam int unsigned MAX_WINDOW = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } imavg_state_e;

endpackage

>>> rtl/imavg_ram.sv
`timescale 1ns / 1ps

module imavg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/imavg_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module imavg_div #(
  parameter int unsigned DividendW = 22,
  parameter int unsigned DivisorW  = 7,
  parameter int unsigned QuoW      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [QuoW-1:0]      quotient_o
);

  localparam int unsigned RemW = DivisorW + 1;
  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [RemW-1:0]      rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [RemW-1:0] shifted;
  logic [RemW:0]   diff;

  // The remainder always stays below the divisor, so its top bit is free
  // to take the next dividend bit.
  assign shifted = {rem_q[RemW-2:0], quo_q[DividendW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DividendW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[RemW]) begin
        rem_d = diff[RemW-1:0];
        quo_d = {quo_q[DividendW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DividendW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[QuoW-1:0];

endmodule

>>> rtl/integer_moving_average_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   sample_i        (16 bits, unsigned)
// output    out        out_valid_o / out_stall_i average_o       (16 bits, unsigned)
// config    in         cfg_we_i                  window_size_i   (7 bits, unsigned)
//
// An accepted sample updates the ring and the running sum; the restoring divider then
// produces one quotient bit per cycle, and the result is loaded into the output register
// once that is free. The next sample is taken only after the return to idle.
// Reset leaves the window at 16 and the filter empty; the ring memory is not cleared,
// because entries at or above the fill count read as zero.
// A stalled result waits in the output register while the next sample is processed.
module integer_moving_average_unit #(
  parameter int unsigned MaxWindow = imavg_pkg::MAX_WINDOW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [imavg_pkg::WIN_CFG_W-1:0] window_size_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [imavg_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [imavg_pkg::AVG_W-1:0]     average_o
);

  import imavg_pkg::*;

  // The window register holds values up to MaxWindow. The running sum needs room
  // for MaxWindow full-scale samples, and the ring index addresses MaxWindow entries.
  localparam int unsigned WinW   = $clog2(MaxWindow + 1);
  localparam int unsigned IdxW   = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned SumW   = SAMPLE_W + ((MaxWindow > 1) ? $clog2(MaxWindow) : 0);
  localparam int unsigned WinRst = (DEF_WINDOW > MaxWindow) ? MaxWindow : DEF_WINDOW;

  imavg_state_e state_q, state_d;

  logic [WinW-1:0]     win_q, win_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [WinW-1:0]     fill_q, fill_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic [AVG_W-1:0]    out_q;
  logic                out_valid_q, out_valid_d;

  logic                in_accept;
  logic                out_free;
  logic                upd_en;
  logic                out_load;
  logic [WinW-1:0]     win_cfg;
  logic [SAMPLE_W-1:0] ring_rdata;
  logic [SAMPLE_W-1:0] old_sample;
  logic [WinW-1:0]     head_ext;
  logic                div_done;
  logic [AVG_W-1:0]    quotient;

  // A sample is taken only in the idle state; the ring read for its slot is issued
  // in the same cycle so the old entry is ready for the update.
  assign in_accept = in_valid_i && !in_stall_o;

  // The output register may be reloaded when it is empty or drained in this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    upd_en     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_UPDATE: begin
        upd_en = 1'b1;
      end
      ST_DIVIDE: begin
        out_load = 1'b0;
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // A window write saturates to the range 1..MaxWindow.
  always_comb begin
    if (window_size_i == '0) begin
      win_cfg = WinW'(1);
    end else if (32'(window_size_i) > MaxWindow) begin
      win_cfg = WinW'(MaxWindow);
    end else begin
      win_cfg = WinW'(window_size_i);
    end
  end

  // Since the last clear the ring has been written from slot zero upward, so any slot
  // at or above the fill count holds no sample of the current window and reads as zero.
  assign head_ext   = WinW'(head_q);
  assign old_sample = (head_ext < fill_q) ? ring_rdata : '0;

  always_comb begin
    win_d  = win_q;
    sum_d  = sum_q;
    head_d = head_q;
    fill_d = fill_q;
    if (cfg_we_i) begin
      win_d  = win_cfg;
      sum_d  = '0;
      head_d = '0;
      fill_d = '0;
    end else if (upd_en) begin
      sum_d = sum_q - SumW'(old_sample) + SumW'(sample_q);
      if (head_ext + WinW'(1) == win_q) begin
        head_d = '0;
      end else begin
        head_d = head_q + IdxW'(1);
      end
      if (fill_q < win_q) begin
        fill_d = fill_q + WinW'(1);
      end
    end
  end

  // The output register holds a result until the transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WinW'(WinRst);
      sum_q       <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      sum_q       <= sum_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
    if (out_load) begin
      out_q <= quotient;
    end
  end

  // Sample ring: read at the head when a sample is accepted, written there on update.
  imavg_ram #(
    .Width (SAMPLE_W),
    .Depth (MaxWindow)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (upd_en),
    .waddr_i (head_q),
    .wdata_i (sample_q),
    .re_i    (in_accept),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  // The divider starts on the freshly updated sum and fill count.
  imavg_div #(
    .DividendW (SumW),
    .DivisorW  (WinW),
    .QuoW      (AVG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (upd_en),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o = out_valid_q;
  assign average_o   = out_q;

endmodule

>>> rtl/imavg_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module imavg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] average_o
);

  // The block works on one sample at a time, so it stalls right after a transaction.
  `IMAVG_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result is loaded only as the sequencer returns to idle.
  `IMAVG_ASSERT_IMP(a_idle_on_result, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

  // A stalled result stays offered.
  `IMAVG_ASSERT_NXT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result does not change.
  `IMAVG_ASSERT_NXT(a_out_data_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
                    $stable(average_o))

endmodule

bind integer_moving_average_unit imavg_checker u_imavg_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

// The bench checks the moving-average unit by running every accepted sample through
// a predictor that keeps its own sample ring, running sum, write position and fill
// count. Each average that leaves the block is compared with the oldest prediction.
// Window writes happen only while the block is idle. Each write both sets the window
// and empties the filter, in the block and in the predictor alike.
module testbench;
  import imavg_pkg::*;

  localparam int unsigned ItemGoal      = 1500;
  // This settle time is a little longer than the block needs for one sample.
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned PressureHold  = 400;
  localparam int unsigned MaxReported   = 10;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [WIN_CFG_W-1:0]  window_size_i = WIN_CFG_W'(DEF_WINDOW);
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   sample_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [AVG_W-1:0]      average_o;

  integer_moving_average_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .window_size_i(window_size_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .average_o    (average_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The predictor's copy of the filter state and of the window register.
  logic [SAMPLE_W-1:0] ring_copy [MAX_WINDOW];
  logic [21:0]         sum_copy;
  int unsigned         head_copy;
  int unsigned         fill_copy;
  int unsigned         window_copy;

  logic [AVG_W-1:0] expected_averages [$];

  int unsigned samples_sent   = 0;
  int unsigned averages_seen  = 0;
  int unsigned window_writes  = 0;
  int unsigned mismatches     = 0;

  // Sender pacing: a burst of back-to-back transactions, then a random gap.
  int unsigned gap_max    = 0;
  int unsigned burst_left = 0;

  // Receiver pacing: 0 never stalls, 1 stalls in short runs, 2 stalls in long runs.
  // A hold request overrides the pattern for the given number of cycles.
  int unsigned stall_level  = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned run_left     = 0;
  logic        stall_phase  = 1'b0;

  task automatic clear_filter_copy();
    foreach (ring_copy[i]) ring_copy[i] = '0;
    sum_copy  = '0;
    head_copy = 0;
    fill_copy = 0;
  endtask

  // Advances the predicted filter by one sample and returns the average it yields.
  function automatic logic [AVG_W-1:0] next_average(input logic [SAMPLE_W-1:0] s);
    logic [21:0] quotient;
    sum_copy = sum_copy - 22'(ring_copy[head_copy]) + 22'(s);
    ring_copy[head_copy] = s;
    head_copy = (head_copy + 1) % window_copy;
    if (fill_copy < window_copy) fill_copy++;
    quotient = sum_copy / 22'(fill_copy);
    return quotient[AVG_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [AVG_W-1:0] want,
                               input logic [AVG_W-1:0] got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("%0t: %s: expected average %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Offers one sample and returns in the cycle it is accepted. The valid stays high
  // afterwards so that a following call continues the burst without a bubble.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_averages.push_back(next_average(s));
    samples_sent++;
    burst_left--;
  endtask

  // Stops offering, then waits until every predicted average has come out and the
  // block has had time to finish any work still in flight.
  task automatic wait_for_averages();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the window register while the block is idle. Out-of-range values are
  // saturated by the block, and every write empties the filter.
  task automatic write_window(input logic [WIN_CFG_W-1:0] value);
    wait_for_averages();
    cfg_we_i      <= 1'b1;
    window_size_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (value == 0) window_copy = 1;
    else if (value > MAX_WINDOW) window_copy = MAX_WINDOW;
    else window_copy = value;
    clear_filter_copy();
    window_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned style);
    case (style)
      0: return SAMPLE_W'($urandom_range(0, 16'hFFFF));
      1: return 16'hFFFF;
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3: return SAMPLE_W'($urandom_range(0, 15));
      default: return SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
    endcase
  endfunction

  // Receiver stall pattern, with its own counter for the long hold-off.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (run_left == 0) begin
        stall_phase = !stall_phase;
        if (stall_phase) run_left = (stall_level == 2) ? $urandom_range(1, 30)
                                                        : $urandom_range(1, 4);
        else run_left = (stall_level == 2) ? $urandom_range(1, 6)
                                           : $urandom_range(1, 20);
      end
      run_left--;
      out_stall_i <= stall_phase && (stall_level != 0);
    end
  end

  // Every accepted average is matched against the oldest prediction.
  always @(posedge clk_i) begin
    logic [AVG_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      averages_seen++;
      if (expected_averages.size() == 0) begin
        note_mismatch("average with none predicted", '0, average_o);
      end else begin
        want = expected_averages.pop_front();
        if (average_o !== want) note_mismatch("average mismatch", want, average_o);
      end
    end
  end

  // After reset the window is 16. Full-scale samples overflow the start-up window
  // and wrap the ring, then zeros and mid-scale values pull the average down.
  task automatic test_default_window();
    repeat (17) send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
  endtask

  // A window of one passes each sample straight through.
  task automatic test_window_of_one();
    write_window(7'd1);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h1234);
  endtask

  // Zero saturates to one; values above the maximum saturate to the largest window.
  task automatic test_window_saturation();
    write_window(7'd0);
    send_sample(16'hABCD);
    send_sample(16'h0001);
    write_window(7'h7F);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    write_window(WIN_CFG_W'(MAX_WINDOW + 1));
    send_sample(16'h5555);
    send_sample(16'hAAAA);
  endtask

  // A short window wraps several times, so the oldest entry really leaves the sum.
  task automatic test_short_wrap();
    write_window(7'd3);
    send_sample(16'd9);
    send_sample(16'd0);
    send_sample(16'd3);
    send_sample(16'd100);
    send_sample(16'd7);
    send_sample(16'hFFFF);
  endtask

  // Phases of random length under random windows, sample styles and pacing. Long
  // all-max phases in the largest window drive the running sum to its ceiling.
  task automatic test_random_windows();
    int unsigned goal;
    int unsigned count;
    int unsigned style;
    logic [WIN_CFG_W-1:0] value;
    goal = samples_sent + ItemGoal;
    while (samples_sent < goal) begin
      case ($urandom_range(0, 9))
        0: value = 7'd1;
        1: value = WIN_CFG_W'(MAX_WINDOW);
        2: value = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(MAX_WINDOW + 1, 127));
        default: value = WIN_CFG_W'($urandom_range(1, MAX_WINDOW));
      endcase
      write_window(value);
      stall_level = $urandom_range(0, 2);
      gap_max = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      style = $urandom_range(0, 4);
      count = $urandom_range(1, 2 * window_copy + 8);
      repeat (count) send_sample(pick_sample(style));
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering in one
  // unbroken burst, so the output register and the datapath fill and the input stalls.
  task automatic test_output_backpressure();
    write_window(7'd8);
    stall_level = 0;
    gap_max = 0;
    hold_request = PressureHold;
    repeat (40) send_sample(pick_sample(0));
    wait_for_averages();
  endtask

  initial begin
    window_copy = DEF_WINDOW;
    clear_filter_copy();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_window();
    test_window_of_one();
    test_window_saturation();
    test_short_wrap();
    test_random_windows();
    test_output_backpressure();
    wait_for_averages();

    if (expected_averages.size() != 0) begin
      mismatches += expected_averages.size();
      $display("%0d predicted averages never arrived", expected_averages.size());
    end
    $display("Covered %0d samples and %0d averages across %0d window settings,",
             samples_sent, averages_seen, window_writes);
    $display("including saturated windows, full-scale sums and a long output hold-off.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Generous bound on the whole run: far beyond the slowest correct pacing.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/imavg_pkg.sv
rtl/imavg_ram.sv
rtl/imavg_div.sv
rtl/integer_moving_average_unit.sv
rtl/imavg_checker.sv
test/testbench.sv
